/* rtl/sorted_priority_queue_defines.svh */
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SPQ_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SPQ_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Types and codes shared by the sorted priority queue modules.
`default_nettype none

package spq_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   // Per-cell command for one cycle.
   typedef struct packed {
      logic insert;
      logic remove;
      logic occupied;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* rtl/spq_cell.sv */
// One slot of the sorted queue: holds an entry, shifts toward head or tail.
`default_nettype none

module spq_cell #(
   parameter int PAYLOAD_BITS = 32
) (
   input  wire                      clock,
   input  spq_pkg::cell_ctrl_type   ctrl,
   input  wire  [PAYLOAD_BITS-1:0]  new_payload,
   input  wire  [7:0]               new_rank,
   input  wire                      left_ge,
   input  wire  [PAYLOAD_BITS-1:0]  left_payload,
   input  wire  [7:0]               left_rank,
   input  wire  [PAYLOAD_BITS-1:0]  right_payload,
   input  wire  [7:0]               right_rank,
   output logic                     ge,
   output logic [PAYLOAD_BITS-1:0]  payload,
   output logic [7:0]               rank
);
   import spq_pkg::*;

   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic [7:0]              rank_ff, rank_in;

   // Occupied entries of equal or higher rank stay ahead of a new entry.
   assign ge = ctrl.occupied && (rank_ff >= new_rank);

   always_comb begin
      payload_in = payload_ff;
      rank_in    = rank_ff;
      priority if (ctrl.insert) begin
         priority if (ge) begin
            payload_in = payload_ff;
            rank_in    = rank_ff;
         end else if (left_ge) begin
            payload_in = new_payload;
            rank_in    = new_rank;
         end else begin
            payload_in = left_payload;
            rank_in    = left_rank;
         end
      end else if (ctrl.remove) begin
         payload_in = right_payload;
         rank_in    = right_rank;
      end else begin
         payload_in = payload_ff;
         rank_in    = rank_ff;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      rank_ff    <= rank_in;
   end

   assign payload = payload_ff;
   assign rank    = rank_ff;

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue top level: a row of shifting slots and the fill count.
//
// Command channel: an item (req_operation, req_payload, req_rank) is taken at
// a rising edge with start high and busy low. busy stays low: every slot
// compares and shifts in the same cycle, so one insert or remove is taken in
// every cycle. An insert goes behind all held entries of equal or higher
// rank; a remove drops the head.
// Result channel: in the cycle after each accepted item, rsp_valid is high for
// exactly one cycle with the head entry, empty flag, entry count and error
// code as they stand after that item. The receiver cannot stall; a result
// not taken in its cycle is gone. Head fields read zero when empty.
// Throughput is one item per cycle, set by the single
// compare-and-shift step in each slot.
// Reset (synchronous) empties the queue and clears the strobe; slot contents
// are not cleared and never read before they are written.
`default_nettype none

module sorted_priority_queue #(
   parameter int DEPTH        = 16,
   parameter int PAYLOAD_BITS = 32,
   localparam int CNT_W       = $clog2(DEPTH + 1)
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire                      req_operation,
   input  wire  [PAYLOAD_BITS-1:0]  req_payload,
   input  wire  [7:0]               req_rank,
   output logic                     rsp_valid,
   output logic [PAYLOAD_BITS-1:0]  rsp_head_payload,
   output logic [7:0]               rsp_head_rank,
   output logic                     rsp_empty_flag,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic [1:0]               rsp_error_code
);
   import spq_pkg::*;

   `include "sorted_priority_queue_defines.svh"

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             valid_ff;
   err_type          err_ff, err_in;
   logic             accept, do_insert, do_remove;

   logic [PAYLOAD_BITS-1:0] slot_payload [DEPTH];
   logic [7:0]              slot_rank    [DEPTH];
   logic                    slot_ge      [DEPTH];

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign do_insert = accept && (req_operation == OP_INSERT) && (fill_ff != FULL_COUNT);
   assign do_remove = accept && (req_operation == OP_REMOVE) && (fill_ff != '0);

   always_comb begin
      fill_in = fill_ff;
      err_in  = ERR_NONE;
      if (req_operation == OP_INSERT) begin
         if (fill_ff == FULL_COUNT) begin
            err_in = ERR_FULL;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end else begin
         if (fill_ff == '0) begin
            err_in = ERR_EMPTY;
         end else begin
            fill_in = fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
      if (accept) begin
         err_ff <= err_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      cell_ctrl_type           ctrl;
      logic                    left_ge;
      logic [PAYLOAD_BITS-1:0] left_payload, right_payload;
      logic [7:0]              left_rank, right_rank;

      assign ctrl.insert   = do_insert;
      assign ctrl.remove   = do_remove;
      assign ctrl.occupied = (CNT_W'(i) < fill_ff);

      if (i == 0) begin : g_head
         assign left_ge      = 1'b1;
         assign left_payload = req_payload;
         assign left_rank    = req_rank;
      end else begin : g_body
         assign left_ge      = slot_ge[i-1];
         assign left_payload = slot_payload[i-1];
         assign left_rank    = slot_rank[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         // Last slot holds its own entry on a remove.
         assign right_payload = slot_payload[i];
         assign right_rank    = slot_rank[i];
      end else begin : g_inner
         assign right_payload = slot_payload[i+1];
         assign right_rank    = slot_rank[i+1];
      end

      spq_cell #(
         .PAYLOAD_BITS(PAYLOAD_BITS)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .new_payload  (req_payload),
         .new_rank     (req_rank),
         .left_ge      (left_ge),
         .left_payload (left_payload),
         .left_rank    (left_rank),
         .right_payload(right_payload),
         .right_rank   (right_rank),
         .ge           (slot_ge[i]),
         .payload      (slot_payload[i]),
         .rank         (slot_rank[i])
      );
   end

   assign rsp_valid        = valid_ff;
   assign rsp_empty_flag   = (fill_ff == '0);
   assign rsp_head_payload = rsp_empty_flag ? '0 : slot_payload[0];
   assign rsp_head_rank    = rsp_empty_flag ? 8'd0 : slot_rank[0];
   assign rsp_entry_count  = fill_ff;
   assign rsp_error_code   = err_ff;

   `SPQ_CHECK(a_beat_follows_accept, accept |=> rsp_valid, "accepted item gave no result beat")
   `SPQ_CHECK(a_fill_bounded, fill_ff <= FULL_COUNT, "fill count beyond depth")
   `SPQ_CHECK(a_full_error_count, (rsp_valid && rsp_error_code == ERR_FULL) |-> (fill_ff == FULL_COUNT), "full error with room left")
   `SPQ_CHECK(a_head_sorted, (fill_ff >= CNT_W'(2)) |-> (slot_rank[0] >= slot_rank[1]), "head rank below second entry")
   `SPQ_CHECK_ALWAYS(a_reset_clears, reset |=> (!rsp_valid && fill_ff == '0), "reset left state")

endmodule

`default_nettype wire
